/* rtl/srot_pkg.sv */
package srot_pkg;

    // Fixed field widths
    localparam int KEY_W      = 10;
    localparam int VAL_PORT_W = 64;
    localparam int CNT_W      = 8;
    localparam int CAP_W      = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd8;
    localparam logic [CNT_W-1:0] CNT_MAX   = 8'hFF;

    // Request opcodes
    localparam logic OP_SET = 1'b0;
    localparam logic OP_GET = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_ADDR,
        ST_SRCH_CMP,
        ST_VAL_RD,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;       // capture request, open search window
        logic key_rd;      // read key at window midpoint
        logic cmp;         // narrow window from compare result
        logic val_rd;      // read value at hit slot
        logic val_wr;      // overwrite value at hit slot
        logic shift_init;  // load shift index with stored count
        logic shift_rd;    // read entry below shift index
        logic shift_wr;    // write that entry one slot up
        logic ins;         // write new pair at insertion point
        logic cnt_inc;     // bump required count
        logic out_load;    // load result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op_get;
        logic active;      // search window not empty
        logic key_eq;
        logic room;        // free usable slot left
        logic more;        // entries still to move up
        logic out_free;    // result register can take a new result
    } status_t;

endpackage

/* rtl/srot_ifs.sv */
interface srot_req_if import srot_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [KEY_W-1:0]  reg_number;
    logic [VAL_PORT_W-1:0] reg_value;

    modport source (output valid, output op, output reg_number, output reg_value,
                    input ready);
    modport sink   (input valid, input op, input reg_number, input reg_value,
                    output ready);
endinterface

interface srot_rsp_if import srot_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [VAL_PORT_W-1:0] value_out;
    logic [CNT_W-1:0]  required_count;
    logic              overflow;

    modport source (output valid, output found, output value_out,
                    output required_count, output overflow, input ready);
    modport sink   (input valid, input found, input value_out,
                    input required_count, input overflow, output ready);
endinterface

interface srot_cfg_if import srot_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CAP_W-1:0]  capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

/* rtl/sorted_register_override_table.sv */
// Sorted register override table.
// Holds up to DEPTH (register number, value) pairs sorted by number.
// req channel: op 0 sets reg_number to reg_value, op 1 looks it up.
// rsp channel: one result per request with found, value_out (lookup hit
//   only), required_count (missed sets so far, saturating at 255) and
//   overflow (required_count above capacity).
// cfg channel: writes capacity; always ready, write only while idle.
// One request is in work at a time. The search is a binary search over
// the stored entries; each probe is a key memory read, then a compare.
// A miss ends when the search window is empty; an insert then moves each
// larger entry up one slot (a read, then a write) and writes the new pair.
// A hit skips the empty-window check; a lookup hit then reads its value.
// The result becomes valid in the same cycle the next transfer can happen.
// With 16 entries a search takes at most 5 probes.
// The result sits in an output register; while rsp is stalled the block
// finishes the next request's search and waits before loading its result.
// Reset clears the stored count, required count and the result valid flag
// and sets capacity to 8; table contents are not cleared.
module sorted_register_override_table import srot_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    srot_cfg_if.sink  cfg,
    srot_req_if.sink  req,
    srot_rsp_if.source rsp
);

    cmd_t    cmd;
    status_t status;
    logic    req_ready;

    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

    // Sequencer
    srot_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Table, search window and result register
    srot_dp #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_op       (req.op),
        .req_number   (req.reg_number),
        .req_value    (req.reg_value),
        .cfg_write    (cfg.valid),
        .cfg_capacity (cfg.capacity),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .rsp_found    (rsp.found),
        .rsp_value    (rsp.value_out),
        .rsp_count    (rsp.required_count),
        .rsp_overflow (rsp.overflow)
    );

`ifndef SYNTH
    // One request at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in work");

    // Nonzero value only on a hit
    a_value_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.value_out != '0) |-> rsp.found)
        else $error("value returned without a hit");

    // At most one table write source per cycle
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.shift_wr, cmd.ins, cmd.val_wr}))
        else $error("conflicting table writes");

    // Loaded result is presented
    a_load_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> rsp.valid)
        else $error("loaded result not valid");
`endif

endmodule

/* rtl/srot_ctrl.sv */
module srot_ctrl import srot_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SRCH_ADDR;
                end
            end
            ST_SRCH_ADDR:
            begin
                if (status.active)
                begin
                    state_next = ST_SRCH_CMP;
                end
                else if (!status.op_get && status.room)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SRCH_CMP:
            begin
                if (!status.key_eq)
                begin
                    state_next = ST_SRCH_ADDR;
                end
                else if (status.op_get)
                begin
                    state_next = ST_VAL_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_VAL_RD:
            begin
                state_next = ST_FINISH;
            end
            ST_SHIFT_RD:
            begin
                state_next = status.more ? ST_SHIFT_WR : ST_FINISH;
            end
            ST_SHIFT_WR:
            begin
                state_next = ST_SHIFT_RD;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.start = req_valid;
            end
            ST_SRCH_ADDR:
            begin
                if (status.active)
                begin
                    cmd.key_rd = 1'b1;
                end
                else if (!status.op_get)
                begin
                    // missed set: always counts, inserts only with room
                    cmd.cnt_inc    = 1'b1;
                    cmd.shift_init = status.room;
                end
            end
            ST_SRCH_CMP:
            begin
                cmd.cmp    = 1'b1;
                cmd.val_wr = status.key_eq && !status.op_get;
            end
            ST_VAL_RD:
            begin
                cmd.val_rd = 1'b1;
            end
            ST_SHIFT_RD:
            begin
                cmd.shift_rd = status.more;
                cmd.ins      = !status.more;
            end
            ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/srot_dp.sv */
module srot_dp import srot_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  req_op,
    input  logic [KEY_W-1:0]      req_number,
    input  logic [VAL_PORT_W-1:0] req_value,
    input  logic                  cfg_write,
    input  logic [CAP_W-1:0]      cfg_capacity,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic                  rsp_found,
    output logic [VAL_PORT_W-1:0] rsp_value,
    output logic [CNT_W-1:0]      rsp_count,
    output logic                  rsp_overflow
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Table storage
    logic [KEY_W-1:0]      key_mem [DEPTH];
    logic [VALUE_BITS-1:0] val_mem [DEPTH];
    logic [KEY_W-1:0]      key_rdata_reg;
    logic [VALUE_BITS-1:0] val_rdata_reg;

    logic                  op_reg,        op_next;
    logic [KEY_W-1:0]      key_reg,       key_next;
    logic [VALUE_BITS-1:0] val_reg,       val_next;
    logic [CW-1:0]         lo_reg,        lo_next;
    logic [CW-1:0]         hi_reg,        hi_next;
    logic [IW-1:0]         mid_reg,       mid_next;
    logic [CW-1:0]         idx_reg,       idx_next;
    logic [CW-1:0]         stored_reg,    stored_next;
    logic [CNT_W-1:0]      count_reg,     count_next;
    logic [CAP_W-1:0]      cap_reg,       cap_next;
    logic                  found_reg,     found_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg, out_found_next;
    logic [VAL_PORT_W-1:0] out_value_reg, out_value_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;
    logic                  out_ovf_reg,   out_ovf_next;

    logic [CW:0]           win_sum;
    logic [CW-1:0]         mid_full;
    logic [CW-1:0]         mid_ext;
    logic [CW-1:0]         idx_dec;
    logic                  key_lt;
    logic                  key_eq;

    logic                  key_we, val_we, key_re, val_re;
    logic [IW-1:0]         key_waddr, val_waddr, key_raddr, val_raddr;
    logic [KEY_W-1:0]      key_wdata;
    logic [VALUE_BITS-1:0] val_wdata;

    // Search window arithmetic
    assign win_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_full = win_sum[CW:1];
    assign mid_ext  = CW'(mid_reg);
    assign idx_dec  = idx_reg - 1'b1;
    assign key_eq   = (key_rdata_reg == key_reg);
    assign key_lt   = (key_reg < key_rdata_reg);

    // Status to controller
    always_comb
    begin
        status.op_get   = (op_reg == OP_GET);
        status.active   = (lo_reg < hi_reg);
        status.key_eq   = key_eq;
        status.room     = (32'(stored_reg) < 32'(cap_reg)) && (stored_reg < DEPTH_C);
        status.more     = (idx_reg > lo_reg);
        status.out_free = !out_valid_reg || rsp_ready;
    end

    // Memory port steering: hit slot is mid, insertion point is lo
    always_comb
    begin
        key_re    = cmd.key_rd || cmd.shift_rd;
        key_raddr = cmd.key_rd ? mid_full[IW-1:0] : idx_dec[IW-1:0];
        val_re    = cmd.val_rd || cmd.shift_rd;
        val_raddr = cmd.val_rd ? mid_reg : idx_dec[IW-1:0];

        key_we    = cmd.shift_wr || cmd.ins;
        key_waddr = cmd.shift_wr ? idx_reg[IW-1:0] : lo_reg[IW-1:0];
        key_wdata = cmd.shift_wr ? key_rdata_reg : key_reg;

        val_we    = cmd.shift_wr || cmd.ins || cmd.val_wr;
        if (cmd.shift_wr)
        begin
            val_waddr = idx_reg[IW-1:0];
            val_wdata = val_rdata_reg;
        end
        else if (cmd.val_wr)
        begin
            val_waddr = mid_reg;
            val_wdata = val_reg;
        end
        else
        begin
            val_waddr = lo_reg[IW-1:0];
            val_wdata = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (key_re)
        begin
            key_rdata_reg <= key_mem[key_raddr];
        end
        if (val_re)
        begin
            val_rdata_reg <= val_mem[val_raddr];
        end
    end

    // Next values
    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        idx_next       = idx_reg;
        stored_next    = stored_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        found_next     = found_reg;
        out_found_next = out_found_reg;
        out_value_next = out_value_reg;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !rsp_ready;

        if (cmd.start)
        begin
            op_next    = req_op;
            key_next   = req_number;
            val_next   = req_value[VALUE_BITS-1:0];
            lo_next    = '0;
            hi_next    = stored_reg;
            found_next = 1'b0;
        end
        if (cmd.key_rd)
        begin
            mid_next = mid_full[IW-1:0];
        end
        if (cmd.cmp)
        begin
            if (key_eq)
            begin
                found_next = 1'b1;
            end
            else if (key_lt)
            begin
                hi_next = mid_ext;
            end
            else
            begin
                lo_next = mid_ext + 1'b1;
            end
        end
        if (cmd.shift_init)
        begin
            idx_next = stored_reg;
        end
        if (cmd.shift_wr)
        begin
            idx_next = idx_dec;
        end
        if (cmd.ins)
        begin
            stored_next = stored_reg + 1'b1;
        end
        if (cmd.cnt_inc && (count_reg != CNT_MAX))
        begin
            count_next = count_reg + 1'b1;
        end
        if (cfg_write)
        begin
            cap_next = cfg_capacity;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_found_next = found_reg;
            out_value_next = (op_reg == OP_GET && found_reg) ?
                             VAL_PORT_W'(val_rdata_reg) : '0;
            out_count_next = count_reg;
            out_ovf_next   = (count_reg > CNT_W'(cap_reg));
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            idx_reg       <= '0;
            stored_reg    <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            found_reg     <= 1'b0;
            op_reg        <= OP_SET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            idx_reg       <= idx_next;
            stored_reg    <= stored_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            found_reg     <= found_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        val_reg       <= val_next;
        out_found_reg <= out_found_next;
        out_value_reg <= out_value_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign rsp_valid    = out_valid_reg;
    assign rsp_found    = out_found_reg;
    assign rsp_value    = out_value_reg;
    assign rsp_count    = out_count_reg;
    assign rsp_overflow = out_ovf_reg;

endmodule
